// ===== src/rol_pkg.sv =====
package rol_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int SIZE_BITS_DEF = 16;
	localparam int ADDR_W        = 32;
	localparam int IN_SIZE_W     = 16;
	localparam int OUT_SIZE_W    = 16;
	localparam int OFFSET_W      = 20;

	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_FIND = 1'b1
	} cmd_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctrl_t;

	function automatic int unsigned wrap_inc(input int unsigned i, input int unsigned n);
		return (i + 1 >= n) ? 0 : i + 1;
	endfunction

endpackage

// ===== src/rol_store.sv =====
module rol_store #(
	parameter int SLOTS     = rol_pkg::SLOTS_DEF,
	parameter int SIZE_BITS = rol_pkg::SIZE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rol_pkg::store_ctrl_t       ctrl,
	input  logic [rol_pkg::ADDR_W-1:0] wr_address,
	input  logic [SIZE_BITS-1:0]       wr_size,
	input  logic [$clog2(SLOTS)-1:0]   rd_idx,
	output logic [$clog2(SLOTS)-1:0]   oldest_idx,
	output logic [rol_pkg::ADDR_W-1:0] rd_address_s1,
	output logic [SIZE_BITS-1:0]       rd_size_s1,
	output logic                       rd_valid_s1
);
	import rol_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic [ADDR_W-1:0]    mem_address [SLOTS];
	logic [SIZE_BITS-1:0] mem_size    [SLOTS];
	logic [SLOTS-1:0]     valid_q;
	logic [IDX_W-1:0]     write_q;
	logic [IDX_W-1:0]     oldest_q;
	logic                 full_q;
	logic [IDX_W-1:0]     write_next;
	logic [IDX_W-1:0]     oldest_next;
	logic [IDX_W-1:0]     oldest_new;

	assign write_next  = IDX_W'(wrap_inc(int'(write_q), SLOTS));
	assign oldest_next = IDX_W'(wrap_inc(int'(oldest_q), SLOTS));
	assign oldest_new  = full_q ? oldest_next : oldest_q;
	assign oldest_idx  = oldest_q;

	// record memory, one write and one read port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_address[write_q] <= wr_address;
			mem_size[write_q]    <= wr_size;
		end
		if (ctrl.rd_en) begin
			rd_address_s1 <= mem_address[rd_idx];
			rd_size_s1    <= mem_size[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			write_q     <= '0;
			oldest_q    <= '0;
			full_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				valid_q[write_q] <= (wr_address != '0);
				write_q          <= write_next;
				oldest_q         <= oldest_new;
				full_q           <= (write_next == oldest_new);
			end
			if (ctrl.rd_en) begin
				rd_valid_s1 <= valid_q[rd_idx];
			end
		end
	end

endmodule

// ===== src/ring_of_writes_offset_lookup.sv =====
// Ring of SLOTS write records (address, size, valid) with an offset lookup.
// An add stores a record at the write slot, valid when its address is nonzero;
// on a full ring it overwrites the oldest record. A find walks the valid
// records from the oldest, summing sizes, and returns the record holding
// char_position with the byte position inside it, or all zeros if none does.
// One command is handled at a time and in_ready is low while it runs. A find
// walks the ring reading one record per cycle through the single read port of
// the record memory. A finished result waits in the output register while the
// next command is accepted.
module ring_of_writes_offset_lookup #(
	parameter int SLOTS     = rol_pkg::SLOTS_DEF,
	parameter int SIZE_BITS = rol_pkg::SIZE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [rol_pkg::ADDR_W-1:0]     record_address,
	input  logic [rol_pkg::IN_SIZE_W-1:0]  record_size,
	input  logic [rol_pkg::OFFSET_W-1:0]   char_position,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [rol_pkg::ADDR_W-1:0]     hit_address,
	output logic [rol_pkg::OUT_SIZE_W-1:0] hit_size,
	output logic [rol_pkg::OUT_SIZE_W-1:0] byte_in_record
);
	import rol_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TW    = SIZE_BITS + IDX_W + 1;
	localparam int CW    = (TW + 1 > OFFSET_W) ? TW + 1 : OFFSET_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TW-1:0]        total_q;
	logic                 live_s1;
	logic                 last_s1;
	logic                 res_found_q;
	logic [ADDR_W-1:0]    res_address_q;
	logic [OUT_SIZE_W-1:0] res_size_q;
	logic [OUT_SIZE_W-1:0] res_byte_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [ADDR_W-1:0]    hit_address_q;
	logic [OUT_SIZE_W-1:0] hit_size_q;
	logic [OUT_SIZE_W-1:0] byte_q;

	store_ctrl_t          ctrl;
	logic [IDX_W-1:0]     oldest_idx;
	logic [ADDR_W-1:0]    rd_address_s1;
	logic [SIZE_BITS-1:0] rd_size_s1;
	logic                 rd_valid_s1;
	logic                 accept;
	logic                 issue;
	logic [CW-1:0]        sum_c;
	logic [CW-1:0]        offs_c;
	logic [CW-1:0]        diff_c;
	logic                 hit_c;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign issue    = (state_q == ST_FIND) && (cnt_q != CNT_W'(SLOTS));

	assign ctrl.wr_en = accept && (command == CMD_ADD);
	assign ctrl.rd_en = issue;

	rol_store #(
		.SLOTS     (SLOTS),
		.SIZE_BITS (SIZE_BITS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.wr_address    (record_address),
		.wr_size       (SIZE_BITS'(record_size)),
		.rd_idx        (idx_q),
		.oldest_idx    (oldest_idx),
		.rd_address_s1 (rd_address_s1),
		.rd_size_s1    (rd_size_s1),
		.rd_valid_s1   (rd_valid_s1)
	);

	// shared add and compare against the running total
	assign sum_c  = CW'(total_q) + CW'(rd_size_s1);
	assign offs_c = CW'(offset_q);
	assign diff_c = offs_c - CW'(total_q);
	assign hit_c  = live_s1 && rd_valid_s1 && (offs_c < sum_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			offset_q      <= '0;
			idx_q         <= '0;
			cnt_q         <= '0;
			total_q       <= '0;
			live_s1       <= 1'b0;
			last_s1       <= 1'b0;
			res_found_q   <= 1'b0;
			res_address_q <= '0;
			res_size_q    <= '0;
			res_byte_q    <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			hit_address_q <= '0;
			hit_size_q    <= '0;
			byte_q        <= '0;
		end else begin
			live_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_found_q   <= 1'b0;
						res_address_q <= '0;
						res_size_q    <= '0;
						res_byte_q    <= '0;
						if (command == CMD_FIND) begin
							offset_q <= char_position;
							idx_q    <= oldest_idx;
							cnt_q    <= '0;
							total_q  <= '0;
							state_q  <= ST_FIND;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FIND: begin
					if (issue) begin
						idx_q   <= IDX_W'(wrap_inc(int'(idx_q), SLOTS));
						cnt_q   <= cnt_q + 1'b1;
						last_s1 <= (cnt_q == CNT_W'(SLOTS - 1));
					end
					live_s1 <= issue;
					if (hit_c) begin
						res_found_q   <= 1'b1;
						res_address_q <= rd_address_s1;
						res_size_q    <= OUT_SIZE_W'(rd_size_s1);
						res_byte_q    <= diff_c[OUT_SIZE_W-1:0];
						live_s1       <= 1'b0;
						state_q       <= ST_DONE;
					end else if (live_s1 && last_s1) begin
						live_s1 <= 1'b0;
						state_q <= ST_DONE;
					end else if (live_s1 && rd_valid_s1) begin
						total_q <= TW'(sum_c);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						found_q       <= res_found_q;
						hit_address_q <= res_address_q;
						hit_size_q    <= res_size_q;
						byte_q        <= res_byte_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign hit_address    = hit_address_q;
	assign hit_size       = hit_size_q;
	assign byte_in_record = byte_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOTS))
		else $error("walk counter past ring depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> hit_address_q == '0 && hit_size_q == '0 && byte_q == '0)
		else $error("miss or add result not all zero");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> hit_address_q != '0)
		else $error("hit on a record with zero address");

	a_byte_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> (SIZE_BITS > OUT_SIZE_W) || (byte_q < hit_size_q))
		else $error("byte position outside the hit record");

	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		live_s1 |-> state_q == ST_FIND)
		else $error("walk stage live outside a find");

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rol_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int PTR_W       = $clog2(SLOTS);
	localparam int RANDOM_CMDS = 1175;
	localparam int QUIET_TAIL  = 150;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 2 * SLOTS + 8;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_LEN    = 300;

	typedef struct packed {
		cmd_t                  cmd;
		logic [ADDR_W-1:0]     addr;
		logic [IN_SIZE_W-1:0]  size;
		logic [OFFSET_W-1:0]   offset;
	} request_t;

	typedef struct packed {
		logic                  found;
		logic [ADDR_W-1:0]     addr;
		logic [OUT_SIZE_W-1:0] size;
		logic [OUT_SIZE_W-1:0] pos;
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  command = 1'b0;
	logic [ADDR_W-1:0]     record_address = '0;
	logic [IN_SIZE_W-1:0]  record_size = '0;
	logic [OFFSET_W-1:0]   char_position = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  found;
	logic [ADDR_W-1:0]     hit_address;
	logic [OUT_SIZE_W-1:0] hit_size;
	logic [OUT_SIZE_W-1:0] byte_in_record;

	request_t     pending_requests[$];
	lookup_t      expected_lookups[$];
	int unsigned  ring_sizes[$];
	int           request_total = 0;
	int           accepted_count = 0;
	int           mismatches = 0;
	int           idle_cycles = 0;

	// shadow of the record ring
	logic [ADDR_W-1:0]    ring_addr[SLOTS];
	logic [IN_SIZE_W-1:0] ring_size[SLOTS];
	logic                 ring_valid[SLOTS];
	logic [PTR_W-1:0]     ring_wr = '0;
	logic [PTR_W-1:0]     ring_oldest = '0;
	logic                 ring_is_full = 1'b0;

	ring_of_writes_offset_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.record_address(record_address),
		.record_size(record_size),
		.char_position(char_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.hit_address(hit_address),
		.hit_size(hit_size),
		.byte_in_record(byte_in_record)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			ring_addr[i] = '0;
			ring_size[i] = '0;
			ring_valid[i] = 1'b0;
		end
	end

	function automatic logic [PTR_W-1:0] step_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic lookup_t apply_command(input request_t r);
		lookup_t          res;
		int unsigned      sum;
		logic [PTR_W-1:0] idx;
		res = '0;
		if (r.cmd == CMD_ADD) begin
			if (ring_is_full)
				ring_oldest = step_slot(ring_oldest);
			ring_addr[ring_wr] = r.addr;
			ring_size[ring_wr] = r.size;
			ring_valid[ring_wr] = (r.addr != '0);
			ring_wr = step_slot(ring_wr);
			ring_is_full = (ring_wr == ring_oldest);
		end else begin
			sum = 0;
			idx = ring_oldest;
			for (int n = 0; n < SLOTS; n++) begin
				if (ring_valid[idx] && !res.found) begin
					if (r.offset < sum + ring_size[idx]) begin
						res.found = 1'b1;
						res.addr = ring_addr[idx];
						res.size = ring_size[idx];
						res.pos = OUT_SIZE_W'(r.offset - sum);
					end else begin
						sum += ring_size[idx];
					end
				end
				idx = step_slot(idx);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic queue_item(input cmd_t c, input logic [ADDR_W-1:0] a,
			input logic [IN_SIZE_W-1:0] s, input logic [OFFSET_W-1:0] off);
		pending_requests.push_back('{cmd: c, addr: a, size: s, offset: off});
		if (c == CMD_ADD) begin
			ring_sizes.push_back((a != '0) ? s : 0);
			if (ring_sizes.size() > SLOTS)
				void'(ring_sizes.pop_front());
		end
	endtask

	function automatic bit idling_allowed();
		return (accepted_count + QUIET_TAIL < request_total) && ((accepted_count / 200) % 3 != 2);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : driver
		request_t req;
		int       gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap = 0;
		end else if (!in_valid || in_ready) begin
			if (gap != 0) begin
				gap = gap - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req = pending_requests.pop_front();
				command <= req.cmd;
				record_address <= req.addr;
				record_size <= req.size;
				char_position <= req.offset;
				in_valid <= 1'b1;
				if (idling_allowed() && $urandom_range(0, 5) == 0)
					gap = $urandom_range(1, 11);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold to back the block up
	always @(posedge clk or negedge arst_n) begin : receiver
		int  stall;
		int  hold;
		bit  hold_done;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
			hold = 0;
			hold_done = 1'b0;
		end else if (hold != 0) begin
			hold = hold - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AT) begin
			hold_done = 1'b1;
			hold = HOLD_LEN;
			out_ready <= 1'b0;
		end else if (stall != 0) begin
			stall = stall - 1;
			out_ready <= 1'b0;
		end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
			stall = $urandom_range(1, 11) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		lookup_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_lookups.push_back(apply_command('{cmd: cmd_t'(command),
					addr: record_address, size: record_size, offset: char_position}));
				accepted_count <= accepted_count + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result with no transaction pending");
				end else begin
					want = expected_lookups.pop_front();
					if (found !== want.found)
						report_mismatch($sformatf("found %0b, want %0b", found, want.found));
					if (hit_address !== want.addr)
						report_mismatch($sformatf("hit_address %h, want %h",
							hit_address, want.addr));
					if (hit_size !== want.size)
						report_mismatch($sformatf("hit_size %h, want %h", hit_size, want.size));
					if (byte_in_record !== want.pos)
						report_mismatch($sformatf("byte_in_record %h, want %h",
							byte_in_record, want.pos));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int unsigned          sum;
		int unsigned          edge_sum;
		int                   k;
		logic [OFFSET_W-1:0]  off;
		logic [ADDR_W-1:0]    a;
		logic [IN_SIZE_W-1:0] s;

		// empty ring, then records at the extremes and a zero-size one
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h0);
		queue_item(CMD_ADD, 32'h0, 16'hFFFF, 20'hFFFFF);
		queue_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 20'h0);
		queue_item(CMD_ADD, 32'h1, 16'h0, 20'h0);
		queue_item(CMD_ADD, 32'h8000_0000, 16'h1, 20'h0);
		queue_item(CMD_ADD, 32'h1234_5678, 16'h00FF, 20'h0);
		queue_item(CMD_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'h0);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h0FFFE);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h0FFFF);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h10000);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h100FF);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h10100);
		// fill the ring and wrap past the oldest records
		for (int i = 0; i < 13; i++)
			queue_item(CMD_ADD, 32'h100 + i, 16'h10, 20'h0);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'h0);
		queue_item(CMD_FIND, 32'h0, 16'h0, 20'hFFFFF);

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			sum = 0;
			foreach (ring_sizes[j])
				sum += ring_sizes[j];
			if ($urandom_range(0, 99) < 45) begin
				case ($urandom_range(0, 15))
					0, 1:    a = '0;
					2:       a = '1;
					default: a = $urandom;
				endcase
				case ($urandom_range(0, 9))
					0:          s = '0;
					1:          s = '1;
					2, 3, 4, 5: s = IN_SIZE_W'($urandom_range(1, 64));
					default:    s = IN_SIZE_W'($urandom_range(0, 16'hFFFF));
				endcase
				queue_item(CMD_ADD, a, s, OFFSET_W'($urandom_range(0, 20'hFFFFF)));
			end else begin
				case ($urandom_range(0, 9))
					6, 7: begin
						k = $urandom_range(0, ring_sizes.size());
						edge_sum = 0;
						for (int j = 0; j < k; j++)
							edge_sum += ring_sizes[j];
						off = (edge_sum != 0 && $urandom_range(0, 1)) ?
							OFFSET_W'(edge_sum - 1) : OFFSET_W'(edge_sum);
					end
					8:       off = OFFSET_W'(sum);
					9:       off = OFFSET_W'($urandom_range(0, 20'hFFFFF));
					default: off = (sum != 0) ? OFFSET_W'($urandom_range(0, sum - 1)) : '0;
				endcase
				queue_item(CMD_FIND, $urandom, IN_SIZE_W'($urandom_range(0, 16'hFFFF)), off);
			end
		end
		request_total = pending_requests.size();

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
